// ----- hdl/set_assoc_cache_fifo_lru_core_macros.svh -----
// Assertion macros for the set-associative cache core.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SET_ASSOC_CACHE_FIFO_LRU_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_LRU_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SACFL_ASSERT_NOW(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SACFL_ASSERT_NEXT(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
    else $error(msg);

`endif

// ----- hdl/sacfl_pkg.sv -----
// Shared types and constants for the set-associative cache core.
// No dependencies.
package sacfl_pkg;

  localparam int MAX_SETS   = 1024;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_BITS  = 48;

  localparam int CNT_BITS   = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Configuration register reset values
  localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [3:0] INDEX_BITS_RST  = 4'd0;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
  localparam logic       REPLACE_LRU_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2,
    CFG_REPLACE_LRU = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ----- hdl/sacfl_if.sv -----
// Request and result channel interfaces for the set-associative cache core.
// Depends on sacfl_pkg.
interface sacfl_in_if #(
  parameter int ADDR_BITS = sacfl_pkg::ADDR_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, cmd, address, input ready);
  modport sink   (input valid, cmd, address, output ready);
endinterface

interface sacfl_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [sacfl_pkg::WAY_OUT_W-1:0]    way;
  logic                               evicted;
  logic [sacfl_pkg::CNT_BITS-1:0]     hit_count;
  logic [sacfl_pkg::CNT_BITS-1:0]     miss_count;
  logic [sacfl_pkg::CNT_BITS-1:0]     mem_read_count;
  logic [sacfl_pkg::CNT_BITS-1:0]     mem_write_count;

  modport source (output valid, hit, way, evicted, hit_count, miss_count,
                  mem_read_count, mem_write_count, input ready);
  modport sink   (input valid, hit, way, evicted, hit_count, miss_count,
                  mem_read_count, mem_write_count, output ready);
endinterface

// ----- hdl/set_assoc_cache_fifo_lru_core.sv -----
// Top level of the tag-only set-associative cache with FIFO or LRU replacement.
// Depends on sacfl_pkg, sacfl_if, sacfl_ram and the assertion macro header.
//
//   Channel  Dir  Handshake        Payload
//   in_ch    in   valid / ready    cmd, address
//   out_ch   out  valid / ready    hit, way, evicted, four saturating counters
//   cfg_*    in   cfg_we only      cfg_index, cfg_wdata
//
// A request passes through the states accept, set row read, a scan of k ways
// (1 .. ways in use) through the single tag comparator, and a final step that
// writes the row back and loads the result register.
// After reset and after any write to offset_bits, index_bits or ways_in_use,
// a clearing pass empties every set row, one row a cycle, taking no request;
// a stalled result holds the final step.
`include "set_assoc_cache_fifo_lru_core_macros.svh"

module set_assoc_cache_fifo_lru_core #(
  parameter int MAX_SETS  = sacfl_pkg::MAX_SETS,
  parameter int MAX_WAYS  = sacfl_pkg::MAX_WAYS,
  parameter int ADDR_BITS = sacfl_pkg::ADDR_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sacfl_in_if.sink                          in_ch,
  sacfl_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [sacfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacfl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Geometry derived from the build limits
  localparam int LIM    = $clog2(MAX_SETS + 1) - 1;       // largest usable index_bits
  localparam int SET_W  = (LIM > 0) ? LIM : 1;
  localparam int DEPTH  = 1 << LIM;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int TAGS_W = MAX_WAYS * ADDR_BITS;
  localparam int RNKS_W = MAX_WAYS * RANK_W;
  localparam int ROW_W  = MAX_WAYS + TAGS_W + RNKS_W + CNT_W;
  localparam int WX     = (WAY_W > sacfl_pkg::WAY_OUT_W) ? WAY_W : sacfl_pkg::WAY_OUT_W;
  localparam int CB     = sacfl_pkg::CNT_BITS;

  // Configuration registers
  logic [3:0] offset_bits_r;
  logic [3:0] index_bits_r;
  logic [3:0] ways_in_use_r;
  logic       replace_lru_r;
  logic       geo_wr;

  // Sequencer and clearing pass
  sacfl_pkg::state_t state_r, state_nxt;
  logic [SET_W-1:0]  clr_cnt_r;

  // Request held for the duration of the lookup
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic                 cmd_r;
  logic [WAY_W-1:0]     way_cnt_r;
  logic                 hit_r;
  logic                 full_r;

  // Effective geometry
  logic [4:0]       ib_eff;
  logic [CNT_W-1:0] ways_eff;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_in;
  logic [5:0]       low_bits;
  logic [ADDR_BITS-1:0] tag_in;
  logic [MAX_WAYS-1:0]  lane_on;

  // RAM port
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_re;
  logic [ROW_W-1:0] ram_rdata;

  // Row fields as read
  logic [MAX_WAYS-1:0]                 rd_valid;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  rd_tags;
  logic [MAX_WAYS-1:0][RANK_W-1:0]     rd_ranks;
  logic [CNT_W-1:0]                    rd_fill;

  // Shared comparator lane
  logic cur_valid;
  logic hit_now;
  logic scan_last;

  // Row update
  logic [MAX_WAYS-1:0]                 nv;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  nt;
  logic [MAX_WAYS-1:0][RANK_W-1:0]     nr;
  logic [CNT_W-1:0]                    nf;
  logic [CNT_W-1:0]                    fill_m;
  logic [RANK_W-1:0]                   hit_rank;
  logic [WAY_W-1:0]                    free_way;
  logic                                free_found;
  logic [WAY_W-1:0]                    res_way;
  logic [WX-1:0]                       res_way_x;
  logic                                fin_go;
  logic                                in_ready;

  // Counters and result register
  logic [CB-1:0] hits_r, misses_r, reads_r, writes_r;
  logic [CB-1:0] hits_nxt, misses_nxt, reads_nxt, writes_nxt;
  logic          out_valid_r;
  logic          out_hit_r;
  logic [sacfl_pkg::WAY_OUT_W-1:0] out_way_r;
  logic          out_evicted_r;

  // ---------------------------------------------------------------------------
  // Configuration writes; a geometry change drops every line
  // ---------------------------------------------------------------------------
  assign geo_wr = cfg_we && (sacfl_pkg::cfg_reg_t'(cfg_index) != sacfl_pkg::CFG_REPLACE_LRU);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= sacfl_pkg::OFFSET_BITS_RST;
      index_bits_r  <= sacfl_pkg::INDEX_BITS_RST;
      ways_in_use_r <= sacfl_pkg::WAYS_IN_USE_RST;
      replace_lru_r <= sacfl_pkg::REPLACE_LRU_RST;
    end else if (cfg_we) begin
      unique case (sacfl_pkg::cfg_reg_t'(cfg_index))
        sacfl_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        sacfl_pkg::CFG_INDEX_BITS:  index_bits_r  <= cfg_wdata;
        sacfl_pkg::CFG_WAYS_IN_USE: ways_in_use_r <= cfg_wdata;
        sacfl_pkg::CFG_REPLACE_LRU: replace_lru_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Address split: clamp index_bits and ways, then cut set and tag
  // ---------------------------------------------------------------------------
  assign ib_eff = ({2'b00, index_bits_r} > 6'(LIM)) ? 5'(LIM) : {1'b0, index_bits_r};

  always_comb begin
    if (ways_in_use_r == 4'd0) begin
      ways_eff = CNT_W'(1);
    end else if ({2'b00, ways_in_use_r} > 6'(MAX_WAYS)) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_in_use_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      lane_on[i] = (CNT_W'(i) < ways_eff);
    end
  end

  assign set_mask = ~({SET_W{1'b1}} << ib_eff);
  assign set_in   = SET_W'(in_ch.address >> offset_bits_r) & set_mask;
  assign low_bits = 6'(offset_bits_r) + 6'(ib_eff);
  assign tag_in   = in_ch.address & ({ADDR_BITS{1'b1}} << low_bits);

  // ---------------------------------------------------------------------------
  // Set row storage
  // ---------------------------------------------------------------------------
  sacfl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (set_r),
    .rdata (ram_rdata)
  );

  assign rd_valid = ram_rdata[MAX_WAYS-1:0];
  assign rd_tags  = ram_rdata[MAX_WAYS+TAGS_W-1:MAX_WAYS];
  assign rd_ranks = ram_rdata[MAX_WAYS+TAGS_W+RNKS_W-1:MAX_WAYS+TAGS_W];
  assign rd_fill  = ram_rdata[ROW_W-1:MAX_WAYS+TAGS_W+RNKS_W];

  // ---------------------------------------------------------------------------
  // Shared tag comparator: one way per cycle, stop at the first hit
  // ---------------------------------------------------------------------------
  assign cur_valid = rd_valid[way_cnt_r];
  assign hit_now   = cur_valid && (rd_tags[way_cnt_r] == tag_r);
  assign scan_last = (CNT_W'(way_cnt_r) + CNT_W'(1)) == ways_eff;

  // ---------------------------------------------------------------------------
  // Row update for the final step
  // ---------------------------------------------------------------------------
  assign hit_rank = rd_ranks[way_cnt_r];

  always_comb begin
    nv         = rd_valid;
    nt         = rd_tags;
    nr         = rd_ranks;
    nf         = rd_fill;
    fill_m     = rd_fill;
    free_way   = '0;
    free_found = 1'b0;
    if (hit_r) begin
      if (replace_lru_r) begin
        // move the hit line to newest, close the gap above its old rank
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (lane_on[i] && rd_valid[i] && (rd_ranks[i] > hit_rank)) begin
            nr[i] = rd_ranks[i] - RANK_W'(1);
          end
        end
        nr[way_cnt_r] = (rd_fill != '0) ? RANK_W'(rd_fill - CNT_W'(1)) : '0;
      end
    end else begin
      if (full_r) begin
        // evict the oldest line, age every other one down
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (lane_on[i]) begin
            if (rd_ranks[i] == '0) begin
              nv[i] = 1'b0;
            end else begin
              nr[i] = rd_ranks[i] - RANK_W'(1);
            end
          end
        end
        if (fill_m != '0) begin
          fill_m = fill_m - CNT_W'(1);
        end
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (lane_on[i] && !nv[i] && !free_found) begin
          free_way   = WAY_W'(i);
          free_found = 1'b1;
        end
      end
      nv[free_way] = 1'b1;
      nt[free_way] = tag_r;
      nr[free_way] = RANK_W'(fill_m);
      nf = (fill_m < ways_eff) ? (fill_m + CNT_W'(1)) : fill_m;
    end
  end

  assign res_way   = hit_r ? way_cnt_r : free_way;
  assign res_way_x = WX'(res_way);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sacfl_pkg::ST_CLEAR: begin
        if (clr_cnt_r == SET_W'(DEPTH - 1)) begin
          state_nxt = sacfl_pkg::ST_IDLE;
        end
      end
      sacfl_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = sacfl_pkg::ST_READ;
        end
      end
      sacfl_pkg::ST_READ: begin
        state_nxt = sacfl_pkg::ST_SCAN;
      end
      sacfl_pkg::ST_SCAN: begin
        if (hit_now || scan_last) begin
          state_nxt = sacfl_pkg::ST_FINISH;
        end
      end
      sacfl_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = sacfl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sacfl_pkg::ST_CLEAR;
    endcase
    if (geo_wr) begin
      state_nxt = sacfl_pkg::ST_CLEAR;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = {nf, nr, nt, nv};
    fin_go    = 1'b0;
    unique case (state_r)
      sacfl_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      sacfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sacfl_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      sacfl_pkg::ST_SCAN: ;
      sacfl_pkg::ST_FINISH: begin
        fin_go = !out_valid_r || out_ch.ready;
        ram_we = fin_go;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sacfl_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (geo_wr) begin
        clr_cnt_r <= '0;
      end else if (state_r == sacfl_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
    end
  end

  // Hold the request and the running lookup status
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      set_r <= set_in;
      tag_r <= tag_in;
      cmd_r <= in_ch.cmd;
    end
    if (state_r == sacfl_pkg::ST_READ) begin
      way_cnt_r <= '0;
      hit_r     <= 1'b0;
      full_r    <= 1'b1;
    end else if (state_r == sacfl_pkg::ST_SCAN) begin
      if (!cur_valid) begin
        full_r <= 1'b0;
      end
      if (hit_now) begin
        hit_r <= 1'b1;
      end else if (!scan_last) begin
        way_cnt_r <= way_cnt_r + WAY_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Saturating counters and the result register
  // ---------------------------------------------------------------------------
  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    reads_nxt  = reads_r;
    writes_nxt = writes_r;
    if (hit_r) begin
      hits_nxt = (hits_r == '1) ? hits_r : hits_r + CB'(1);
    end else begin
      misses_nxt = (misses_r == '1) ? misses_r : misses_r + CB'(1);
      reads_nxt  = (reads_r == '1) ? reads_r : reads_r + CB'(1);
    end
    if (cmd_r) begin
      writes_nxt = (writes_r == '1) ? writes_r : writes_r + CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        reads_r     <= reads_nxt;
        writes_r    <= writes_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_hit_r     <= hit_r;
      out_way_r     <= res_way_x[sacfl_pkg::WAY_OUT_W-1:0];
      out_evicted_r <= !hit_r && full_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = out_hit_r;
  assign out_ch.way             = out_way_r;
  assign out_ch.evicted         = out_evicted_r;
  assign out_ch.hit_count       = hits_r;
  assign out_ch.miss_count      = misses_r;
  assign out_ch.mem_read_count  = reads_r;
  assign out_ch.mem_write_count = writes_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SACFL_ASSERT_NEXT(a_accept_reads, in_ch.valid && in_ready && !geo_wr, state_r == sacfl_pkg::ST_READ, "accepted request did not start a row read")
  `SACFL_ASSERT_NOW(a_scan_in_range, state_r == sacfl_pkg::ST_SCAN, CNT_W'(way_cnt_r) < ways_eff, "comparator stepped past the ways in use")
  `SACFL_ASSERT_NOW(a_hit_no_evict, out_valid_r && out_hit_r, !out_evicted_r, "hit result reports an eviction")
  `SACFL_ASSERT_NEXT(a_finish_loads, fin_go, out_valid_r, "finished lookup did not load the result register")

endmodule

// ----- hdl/sacfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
